// ===== rtl/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// MAC learning table package
// Shared sizes, codes and record types for the MAC learning table.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 48;
    localparam int HIT_W    = 16;

    localparam logic [HIT_W-1:0] HIT_MAX     = '1;
    localparam logic [15:0]      STALE_RESET = 16'd5000;

    typedef enum logic [1:0] {
        ACT_DETECT   = 2'd0,
        ACT_FIX      = 2'd1,
        ACT_FIX_LOST = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MERGE
    } state_t;

    // Lookup request that walks down the row of cells.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [HIT_W-1:0] hits;
    } token_t;

    // Per-entry attributes that do not take part in the key search.
    typedef struct packed {
        logic [31:0] first_time;
        logic [31:0] last_time;
        logic [23:0] signal_info;
        logic [15:0] label;
        logic [63:0] position;
        logic        position_valid;
    } entry_t;

endpackage

// ===== rtl/mlt_cell.sv =====
// ----------------------------------------------------------------------------
// MAC learning table cell
// Holds one key and its hit count, compares the passing lookup request and
// hands the request on to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module mlt_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [mlt_pkg::IDX_W-1:0]  cell_idx,
    input  logic [mlt_pkg::CNT_W-1:0]  used_count,
    input  mlt_pkg::token_t            tok_in,
    output mlt_pkg::token_t            tok_out,
    input  logic                       wr_en,
    input  logic [mlt_pkg::IDX_W-1:0]  wr_idx,
    input  logic [mlt_pkg::KEY_W-1:0]  wr_key
);

    logic [mlt_pkg::KEY_W-1:0] key_reg;
    logic [mlt_pkg::HIT_W-1:0] hits_reg;
    logic [mlt_pkg::HIT_W-1:0] hits_inc;
    mlt_pkg::token_t           tok_reg;
    mlt_pkg::token_t           tok_next;
    logic                      occupied;
    logic                      match;

    // The cell only answers while its slot lies below the fill count.
    assign occupied = mlt_pkg::CNT_W'(cell_idx) < used_count;
    assign match    = tok_in.valid && !tok_in.found && occupied && (key_reg == tok_in.key);
    assign hits_inc = (hits_reg == mlt_pkg::HIT_MAX) ? hits_reg : hits_reg + 1'b1;

    // Mark the request when this cell holds its key.
    always_comb begin
        tok_next = tok_in;
        if (match) begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_idx;
            tok_next.hits  = hits_inc;
        end
    end

    // Key and count storage: an insert writes, a match bumps the count.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == cell_idx)) begin
            key_reg  <= wr_key;
            hits_reg <= mlt_pkg::HIT_W'(1);
        end else if (match) begin
            hits_reg <= hits_inc;
        end
    end

    // Request stage toward the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/mlt_entry_ram.sv =====
// ----------------------------------------------------------------------------
// MAC learning table entry memory
// Attribute records of the table, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlt_entry_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [mlt_pkg::IDX_W-1:0] wr_addr,
    input  mlt_pkg::entry_t           wr_data,
    input  logic                      rd_en,
    input  logic [mlt_pkg::IDX_W-1:0] rd_addr,
    output mlt_pkg::entry_t           rd_data
);

    mlt_pkg::entry_t mem [mlt_pkg::CAPACITY];
    mlt_pkg::entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mac_learning_table.sv =====
// ----------------------------------------------------------------------------
// MAC learning table
// Insert-or-update table of detected devices keyed by a 48-bit MAC address.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Content
//  s_      | in        | s_tvalid / s_tready     | tuser: action, tdata: detection
//  m_      | out       | m_tvalid / m_tready     | tdata: lookup result
//  cfg_    | in        | cfg_valid / cfg_ready   | fix_stale_ms
//
// A detection walks the row of CAPACITY cells, one cell per cycle, from the
// launch register to the result register, passing the merge state when an
// existing entry is updated. Other actions answer in the cycle after accept.
// One request is in flight at a time; a new one is taken once the result
// register is empty. Reset is synchronous, active low, with no clearing pass.
// ----------------------------------------------------------------------------
module mac_learning_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] action
    input  logic [1:0]   s_tuser,
    // [47:0] mac, [63:48] label_handle, [67:64] method_code, [68] radio_kind,
    // [76:69] rssi, [84:77] channel, [85] special_type, [87:86] firmware_class,
    // [119:88] now_ms, [150:120] latitude, [182:151] longitude, [183] zero
    input  logic [183:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] is_new, [1] dropped, [9:2] entry_index, [25:10] hit_count,
    // [34:26] entries_used, [35] full_seen, [39:36] zero
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    localparam int N = mlt_pkg::CAPACITY;

    // Input field views.
    logic [47:0] in_mac;
    logic [15:0] in_label;
    logic [3:0]  in_method;
    logic        in_radio;
    logic [7:0]  in_rssi;
    logic [7:0]  in_chan;
    logic        in_special;
    logic [1:0]  in_fw;
    logic [31:0] in_now;
    logic [30:0] in_lat;
    logic [31:0] in_lon;
    mlt_pkg::action_t in_action;

    assign in_action  = mlt_pkg::action_t'(s_tuser);
    assign in_mac     = s_tdata[47:0];
    assign in_label   = s_tdata[63:48];
    assign in_method  = s_tdata[67:64];
    assign in_radio   = s_tdata[68];
    assign in_rssi    = s_tdata[76:69];
    assign in_chan    = s_tdata[84:77];
    assign in_special = s_tdata[85];
    assign in_fw      = s_tdata[87:86];
    assign in_now     = s_tdata[119:88];
    assign in_lat     = s_tdata[150:120];
    assign in_lon     = s_tdata[182:151];

    // Control and held state.
    mlt_pkg::state_t state_reg, state_next;
    logic [mlt_pkg::CNT_W-1:0] used_reg, used_next;
    logic [63:0] held_fix_reg, held_fix_next;
    logic        held_valid_reg, held_valid_next;
    logic [31:0] held_time_reg, held_time_next;
    logic        full_reg, full_next;
    logic [15:0] stale_reg;
    logic        fresh_reg, fresh_next;

    // Detection held while it is being looked up.
    logic [15:0] label_reg, label_next;
    logic [7:0]  rssi_reg, rssi_next;
    logic [7:0]  chan_reg, chan_next;
    logic [31:0] now_reg, now_next;
    logic [23:0] sig_reg, sig_next;
    logic [47:0] mac_reg, mac_next;
    logic [mlt_pkg::IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [mlt_pkg::HIT_W-1:0] res_hits_reg, res_hits_next;

    // Result register.
    logic                      m_valid_reg, m_valid_next;
    logic                      o_new_reg, o_new_next;
    logic                      o_drop_reg, o_drop_next;
    logic [mlt_pkg::IDX_W-1:0] o_idx_reg, o_idx_next;
    logic [mlt_pkg::HIT_W-1:0] o_hits_reg, o_hits_next;

    // Cell row, memory and handshake wires.
    mlt_pkg::token_t tok_chain [N+1];
    mlt_pkg::token_t launch_reg, launch_next;
    mlt_pkg::token_t tok_exit;
    logic            cell_wr;
    mlt_pkg::entry_t ram_wdata, ram_rdata, merged;
    logic            ram_wr, ram_rd;
    logic [mlt_pkg::IDX_W-1:0] ram_waddr;
    logic            acc;
    logic            fresh_now;

    assign s_tready  = (state_reg == mlt_pkg::ST_IDLE) && !m_valid_reg;
    assign acc       = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign fresh_now = held_valid_reg && ((in_now - held_time_reg) < {16'b0, stale_reg});

    // Row of cells; each cycle the request moves one cell further.
    assign tok_chain[0] = launch_reg;
    assign tok_exit     = tok_chain[N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        mlt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_idx   (mlt_pkg::IDX_W'(g)),
            .used_count (used_reg),
            .tok_in     (tok_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .wr_en      (cell_wr),
            .wr_idx     (mlt_pkg::IDX_W'(used_reg)),
            .wr_key     (mac_reg)
        );
    end

    mlt_entry_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_rd),
        .rd_addr (tok_exit.idx),
        .rd_data (ram_rdata)
    );

    // Update of an existing record.
    always_comb begin
        merged                  = ram_rdata;
        merged.last_time        = now_reg;
        merged.signal_info[7:0] = rssi_reg;
        if (chan_reg != 8'd0) begin
            merged.signal_info[15:8] = chan_reg;
        end
        if ((label_reg != 16'd0) && (ram_rdata.label == 16'd0)) begin
            merged.label = label_reg;
        end
        if (fresh_reg) begin
            merged.position       = held_fix_reg;
            merged.position_valid = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mlt_pkg::ST_IDLE: begin
                if (acc && (in_action == mlt_pkg::ACT_DETECT)) begin
                    state_next = mlt_pkg::ST_SEARCH;
                end
            end
            mlt_pkg::ST_SEARCH: begin
                if (tok_exit.valid) begin
                    state_next = tok_exit.found ? mlt_pkg::ST_MERGE : mlt_pkg::ST_IDLE;
                end
            end
            mlt_pkg::ST_MERGE: begin
                state_next = mlt_pkg::ST_IDLE;
            end
            default: state_next = mlt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result.
    always_comb begin
        used_next       = used_reg;
        held_fix_next   = held_fix_reg;
        held_valid_next = held_valid_reg;
        held_time_next  = held_time_reg;
        full_next       = full_reg;
        fresh_next      = fresh_reg;
        label_next      = label_reg;
        rssi_next       = rssi_reg;
        chan_next       = chan_reg;
        now_next        = now_reg;
        sig_next        = sig_reg;
        mac_next        = mac_reg;
        res_idx_next    = res_idx_reg;
        res_hits_next   = res_hits_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        o_new_next      = o_new_reg;
        o_drop_next     = o_drop_reg;
        o_idx_next      = o_idx_reg;
        o_hits_next     = o_hits_reg;
        launch_next     = '0;
        cell_wr         = 1'b0;
        ram_wr          = 1'b0;
        ram_rd          = 1'b0;
        ram_waddr       = res_idx_reg;
        ram_wdata       = merged;

        unique case (state_reg)
            mlt_pkg::ST_IDLE: begin
                if (acc) begin
                    o_new_next  = 1'b0;
                    o_drop_next = 1'b0;
                    o_idx_next  = '0;
                    o_hits_next = '0;
                    unique case (in_action)
                        mlt_pkg::ACT_DETECT: begin
                            fresh_next      = fresh_now;
                            label_next      = in_label;
                            rssi_next       = in_rssi;
                            chan_next       = in_chan;
                            now_next        = in_now;
                            mac_next        = in_mac;
                            sig_next        = {in_fw, in_special, in_radio, in_method,
                                               in_chan, in_rssi};
                            launch_next.valid = 1'b1;
                            launch_next.key   = in_mac;
                        end
                        mlt_pkg::ACT_FIX: begin
                            held_fix_next   = {in_lat[30], in_lat, in_lon};
                            held_time_next  = in_now;
                            held_valid_next = 1'b1;
                            m_valid_next    = 1'b1;
                        end
                        mlt_pkg::ACT_FIX_LOST: begin
                            held_valid_next = 1'b0;
                            m_valid_next    = 1'b1;
                        end
                        mlt_pkg::ACT_CLEAR: begin
                            used_next    = '0;
                            m_valid_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            mlt_pkg::ST_SEARCH: begin
                if (tok_exit.valid) begin
                    priority if (tok_exit.found) begin
                        ram_rd        = 1'b1;
                        res_idx_next  = tok_exit.idx;
                        res_hits_next = tok_exit.hits;
                    end else if (used_reg < mlt_pkg::CNT_W'(N)) begin
                        // New key takes the next free slot.
                        cell_wr                  = 1'b1;
                        ram_wr                   = 1'b1;
                        ram_waddr                = mlt_pkg::IDX_W'(used_reg);
                        ram_wdata.first_time     = now_reg;
                        ram_wdata.last_time      = now_reg;
                        ram_wdata.signal_info    = sig_reg;
                        ram_wdata.label          = label_reg;
                        ram_wdata.position       = fresh_reg ? held_fix_reg : 64'd0;
                        ram_wdata.position_valid = fresh_reg;
                        used_next    = used_reg + 1'b1;
                        o_new_next   = 1'b1;
                        o_idx_next   = mlt_pkg::IDX_W'(used_reg);
                        o_hits_next  = mlt_pkg::HIT_W'(1);
                        m_valid_next = 1'b1;
                    end else begin
                        full_next    = 1'b1;
                        o_drop_next  = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            mlt_pkg::ST_MERGE: begin
                ram_wr       = 1'b1;
                o_idx_next   = res_idx_reg;
                o_hits_next  = res_hits_reg;
                m_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mlt_pkg::ST_IDLE;
            used_reg       <= '0;
            held_fix_reg   <= '0;
            held_valid_reg <= 1'b0;
            held_time_reg  <= '0;
            full_reg       <= 1'b0;
            stale_reg      <= mlt_pkg::STALE_RESET;
            m_valid_reg    <= 1'b0;
            launch_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            held_fix_reg   <= held_fix_next;
            held_valid_reg <= held_valid_next;
            held_time_reg  <= held_time_next;
            full_reg       <= full_next;
            m_valid_reg    <= m_valid_next;
            launch_reg     <= launch_next;
            if (cfg_valid) begin
                stale_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        fresh_reg    <= fresh_next;
        label_reg    <= label_next;
        rssi_reg     <= rssi_next;
        chan_reg     <= chan_next;
        now_reg      <= now_next;
        sig_reg      <= sig_next;
        mac_reg      <= mac_next;
        res_idx_reg  <= res_idx_next;
        res_hits_reg <= res_hits_next;
        o_new_reg    <= o_new_next;
        o_drop_reg   <= o_drop_next;
        o_idx_reg    <= o_idx_next;
        o_hits_reg   <= o_hits_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, full_reg, 9'(used_reg), o_hits_reg, 8'(o_idx_reg),
                       o_drop_reg, o_new_reg};

endmodule

// ===== rtl/mlt_checker.sv =====
// ----------------------------------------------------------------------------
// MAC learning table checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mlt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request at a time: no accept while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // A drop always shows the sticky full flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[35])
        else $error("drop without full flag");

    // A new entry has one hit and is never also a drop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[25:10] == 16'd1) && !m_tdata[1])
        else $error("bad new entry result");

endmodule

bind mac_learning_table mlt_checker u_mlt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
